// ===== src/tcs_pkg.sv =====
// ---------------------------------------------------------------------------
// tcs_pkg: shared types and tables for the Thai cell segmenter
// Class codes, check verdicts, the class table and the pair rule tables.
// ---------------------------------------------------------------------------
package tcs_pkg;

    localparam int UNIT_W = 16;
    localparam int IDX_W = 8;
    localparam logic [UNIT_W-1:0] THAI_OFFSET = 16'd3424;
    localparam logic [IDX_W-1:0] TABLE_TOP = 8'd255;
    localparam int NUM_CLASSES = 17;

    localparam logic [2:0] ADDR_CHECK_LEVEL = 3'd0;
    localparam logic [2:0] ADDR_WIDE_UNITS = 3'd4;
    localparam int REG_IDX_BIT = 2;

    typedef enum logic [4:0] {
        CL_CT = 5'd0,  CL_NO = 5'd1,  CL_CO = 5'd2,  CL_LV = 5'd3,
        CL_F1 = 5'd4,  CL_F2 = 5'd5,  CL_F3 = 5'd6,  CL_B1 = 5'd7,
        CL_B2 = 5'd8,  CL_BD = 5'd9,  CL_TO = 5'd10, CL_A1 = 5'd11,
        CL_A2 = 5'd12, CL_A3 = 5'd13, CL_V1 = 5'd14, CL_V2 = 5'd15,
        CL_V3 = 5'd16
    } t_class;

    typedef enum logic [2:0] {
        VD_ACC = 3'd0,
        VD_CMP = 3'd1,
        VD_SWP = 3'd2,
        VD_REJ = 3'd3,
        VD_CTL = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        LV_PASS   = 2'd0,
        LV_BASIC  = 2'd1,
        LV_STRICT = 2'd2,
        LV_RSVD   = 2'd3
    } t_level;

    typedef struct packed {
        t_class unit_class;
        logic   in_range;
    } t_unit_info;

    typedef struct packed {
        logic     joins;
        t_verdict verdict;
        logic     allowed;
    } t_rule_out;

    // bit c of row p: class c stacks onto a cell that ends in class p
    localparam logic [NUM_CLASSES-1:0] JOIN_MASK [NUM_CLASSES] = '{
        17'h00000, 17'h00000, 17'h1FFF0, 17'h00000, 17'h00000, 17'h00000,
        17'h00000, 17'h00C00, 17'h00400, 17'h00000, 17'h00010, 17'h00000,
        17'h00000, 17'h00000, 17'h00C00, 17'h00400, 17'h01400
    };

    localparam t_verdict VERDICT_TBL [NUM_CLASSES][NUM_CLASSES] = '{
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ,
          VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ,
          VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_ACC, VD_SWP, VD_ACC, VD_CMP, VD_CMP,
          VD_CMP, VD_CMP, VD_CMP, VD_CMP, VD_CMP, VD_CMP, VD_CMP, VD_CMP},
        '{VD_CTL, VD_SWP, VD_ACC, VD_SWP, VD_SWP, VD_SWP, VD_SWP, VD_REJ, VD_REJ,
          VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_SWP, VD_ACC, VD_SWP, VD_ACC, VD_SWP, VD_ACC, VD_REJ, VD_REJ,
          VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_ACC, VD_SWP, VD_ACC, VD_REJ, VD_REJ,
          VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_SWP, VD_ACC, VD_SWP, VD_REJ, VD_REJ,
          VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_ACC, VD_SWP, VD_ACC, VD_REJ, VD_REJ,
          VD_REJ, VD_CMP, VD_CMP, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_SWP, VD_SWP, VD_ACC, VD_REJ, VD_REJ,
          VD_REJ, VD_CMP, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_SWP, VD_SWP, VD_ACC, VD_REJ, VD_REJ,
          VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_ACC, VD_ACC, VD_ACC, VD_REJ, VD_REJ,
          VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_SWP, VD_SWP, VD_ACC, VD_REJ, VD_REJ,
          VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_SWP, VD_SWP, VD_ACC, VD_REJ, VD_REJ,
          VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_SWP, VD_SWP, VD_ACC, VD_REJ, VD_REJ,
          VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_SWP, VD_SWP, VD_ACC, VD_REJ, VD_REJ,
          VD_REJ, VD_CMP, VD_CMP, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_SWP, VD_SWP, VD_ACC, VD_REJ, VD_REJ,
          VD_REJ, VD_CMP, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ, VD_REJ},
        '{VD_CTL, VD_ACC, VD_ACC, VD_ACC, VD_SWP, VD_SWP, VD_ACC, VD_REJ, VD_REJ,
          VD_REJ, VD_CMP, VD_REJ, VD_CMP, VD_REJ, VD_REJ, VD_REJ, VD_REJ}
    };

    // TIS-620 byte to character class
    function automatic t_class class_of(input logic [IDX_W-1:0] idx);
        t_class c;
        if (idx < 8'h20) begin
            c = CL_CT;
        end else if (idx < 8'h7F) begin
            c = CL_NO;
        end else if (idx < 8'hA0) begin
            c = CL_CT;
        end else if (idx == 8'hA0) begin
            c = CL_NO;
        end else if (idx < 8'hC0) begin
            c = CL_CO;
        end else if (idx == TABLE_TOP) begin
            c = CL_CT;
        end else begin
            case (idx)
                8'hC4, 8'hC6: c = CL_F3;
                8'hCF:        c = CL_NO;
                8'hD0, 8'hD2, 8'hD3: c = CL_F1;
                8'hD1, 8'hD6: c = CL_V2;
                8'hD4:        c = CL_V1;
                8'hD5, 8'hD7: c = CL_V3;
                8'hD8:        c = CL_B1;
                8'hD9:        c = CL_B2;
                8'hDA:        c = CL_BD;
                8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4: c = CL_LV;
                8'hE5:        c = CL_F2;
                8'hE7:        c = CL_A2;
                8'hE8, 8'hE9, 8'hEA, 8'hEB: c = CL_TO;
                8'hEC, 8'hED: c = CL_A1;
                8'hEE:        c = CL_A3;
                default: begin
                    c = (idx < 8'hCF) ? CL_CO : CL_NO;
                end
            endcase
        end
        return c;
    endfunction

endpackage

// ===== src/tcs_classify.sv =====
// ---------------------------------------------------------------------------
// tcs_classify: text unit to character class
// Maps a byte or a wide code unit into the class table and flags range.
// ---------------------------------------------------------------------------
module tcs_classify
    import tcs_pkg::*;
(
    input  logic [UNIT_W-1:0] i_unit,
    input  logic              i_wide,
    output t_unit_info        o_info
);

    logic [UNIT_W-1:0] diff;
    logic              wide_inr;
    logic [IDX_W-1:0]  idx;

    assign diff = i_unit - THAI_OFFSET;
    assign wide_inr = (i_unit >= THAI_OFFSET) && (diff[UNIT_W-1:IDX_W] == '0);

    always_comb begin
        if (i_wide) begin
            idx = diff[IDX_W-1:0];
            o_info.in_range = wide_inr;
        end else begin
            idx = i_unit[IDX_W-1:0];
            o_info.in_range = 1'b1;
        end
        o_info.unit_class = o_info.in_range ? class_of(idx) : CL_CT;
    end

endmodule

// ===== src/tcs_rules.sv =====
// ---------------------------------------------------------------------------
// tcs_rules: pair rules on previous and current class
// Cell joining, input-check verdict and level filter.
// ---------------------------------------------------------------------------
module tcs_rules
    import tcs_pkg::*;
(
    input  t_class     i_last_class,
    input  logic       i_prev_in_range,
    input  t_unit_info i_cur,
    input  t_level     i_level,
    output t_rule_out  o_rule
);

    t_class prev;

    assign prev = (i_last_class > CL_V3) ? CL_CT : i_last_class;

    always_comb begin
        o_rule.joins = i_prev_in_range && i_cur.in_range &&
                       JOIN_MASK[prev][i_cur.unit_class];
        o_rule.verdict = VERDICT_TBL[prev][i_cur.unit_class];
        case (i_level)
            LV_PASS:   o_rule.allowed = 1'b1;
            LV_BASIC:  o_rule.allowed = (o_rule.verdict != VD_REJ);
            LV_STRICT: o_rule.allowed = (o_rule.verdict != VD_REJ) &&
                                        (o_rule.verdict != VD_SWP);
            default:   o_rule.allowed = 1'b0;
        endcase
    end

endmodule

// ===== src/thai_cell_segmenter.sv =====
// ---------------------------------------------------------------------------
// thai_cell_segmenter: Thai display cell and input sequence check
// Classes each text unit and checks it against the previous unit's class.
//
//   channel  direction  handshake                payload
//   in       to block   i_in_valid / o_in_stall  i_code_unit, i_text_start
//   out      from block o_out_valid / i_out_stall o_joins_previous,
//                                                o_check_verdict, o_allowed,
//                                                o_unit_class, o_in_range
//   cfg      to block   APB psel/penable/pready  check_level, wide_units
//
// One word per cycle while the output is not stalled; a word passes the input register, then the result register.
// The previous-class register updates as a word leaves the input register,
// so the lookup and rule tables sit in one short path between the two.
// Reset clears both stages and sets previous class to control, in range.
// A stall on the output holds both stages; input stall follows when full.
// ---------------------------------------------------------------------------
module thai_cell_segmenter
    import tcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [UNIT_W-1:0] i_code_unit,
    input  logic              i_text_start,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_joins_previous,
    output logic [2:0]        o_check_verdict,
    output logic              o_allowed,
    output logic [4:0]        o_unit_class,
    output logic              o_in_range,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_level            r_level;
    logic              r_wide;
    logic              r_s1_valid;
    logic [UNIT_W-1:0] r_s1_unit;
    logic              r_s1_start;
    t_class            r_last_class;
    logic              r_prev_in_range;
    logic              r_out_valid;
    t_rule_out         r_rule;
    t_unit_info        r_info;

    t_unit_info        cur_info;
    t_rule_out         cur_rule;
    t_class            eff_last_class;
    logic              prev_inr;
    logic              s2_free;
    logic              s1_move;
    logic              s1_free;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LV_BASIC;
            r_wide  <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[REG_IDX_BIT] == ADDR_WIDE_UNITS[REG_IDX_BIT]) begin
                r_wide <= pwdata[0];
            end else begin
                r_level <= t_level'(pwdata[1:0]);
            end
        end
    end

    always_comb begin
        if (paddr[REG_IDX_BIT] == ADDR_CHECK_LEVEL[REG_IDX_BIT]) begin
            prdata = {30'd0, r_level};
        end else begin
            prdata = {31'd0, r_wide};
        end
    end

    assign s2_free = !r_out_valid || !i_out_stall;
    assign s1_move = r_s1_valid && s2_free;
    assign s1_free = !r_s1_valid || s2_free;
    assign o_in_stall = !s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in_valid) begin
            r_s1_unit  <= i_code_unit;
            r_s1_start <= i_text_start;
        end
    end

    tcs_classify u_classify (
        .i_unit (r_s1_unit),
        .i_wide (r_wide),
        .o_info (cur_info)
    );

    assign eff_last_class = r_s1_start ? CL_CT : r_last_class;
    assign prev_inr       = r_s1_start ? 1'b1 : r_prev_in_range;

    tcs_rules u_rules (
        .i_last_class    (eff_last_class),
        .i_prev_in_range (prev_inr),
        .i_cur           (cur_info),
        .i_level         (r_level),
        .o_rule          (cur_rule)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_class    <= CL_CT;
            r_prev_in_range <= 1'b1;
            r_out_valid     <= 1'b0;
        end else begin
            if (s1_move) begin
                r_last_class    <= cur_info.unit_class;
                r_prev_in_range <= cur_info.in_range;
            end
            if (s2_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_rule <= cur_rule;
            r_info <= cur_info;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_joins_previous = r_rule.joins;
    assign o_check_verdict  = r_rule.verdict;
    assign o_allowed        = r_rule.allowed;
    assign o_unit_class     = r_info.unit_class;
    assign o_in_range       = r_info.in_range;

endmodule

// ===== src/tcs_checker.sv =====
// ---------------------------------------------------------------------------
// tcs_checker: port-level checks for the Thai cell segmenter
// Watches the top level ports; attached by bind.
// ---------------------------------------------------------------------------
module tcs_checker
    import tcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_stall,
    input  logic [UNIT_W-1:0] i_code_unit,
    input  logic              i_text_start,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic              o_joins_previous,
    input  logic [2:0]        o_check_verdict,
    input  logic              o_allowed,
    input  logic [4:0]        o_unit_class,
    input  logic              o_in_range,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready
);

    // a held result word keeps its valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid &&
        $stable({o_joins_previous, o_check_verdict, o_allowed,
                 o_unit_class, o_in_range}))
        else $error("output word changed while stalled");

    // no result word straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // out-of-range wide unit is a non-joining control unit
    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_range |-> !o_joins_previous &&
        (o_check_verdict == VD_CTL) && (o_unit_class == CL_CT))
        else $error("out-of-range unit not reported as control");

    // a control, non-Thai or consonant unit never stacks onto a cell
    a_no_join_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_unit_class == CL_CT) || (o_unit_class == CL_NO) ||
        (o_unit_class == CL_CO)) |-> !o_joins_previous)
        else $error("base class unit joined previous cell");

endmodule

bind thai_cell_segmenter tcs_checker u_tcs_checker (.*);
